### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sthc_pkg.sv
// ----------------------------------------------------------------------------
// sthc_pkg
// Types, constants and helper functions of the framed hex-checksum deframer.
// ----------------------------------------------------------------------------
package sthc_pkg;

  localparam int unsigned MAX_FRAME = 512;
  localparam int unsigned CNT_W     = $clog2(MAX_FRAME - 1);
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned TDATA_W   = 32;

  localparam logic [7:0] START_RST = 8'h06;
  localparam logic [7:0] END_RST   = 8'h03;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] CASE_MASK = 8'hDF;
  localparam logic [7:0] HEX_TEN   = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CSUM  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       frame_end;
    status_e    frame_status;
    logic [7:0] received_sum;
    logic [7:0] computed_sum;
  } result_t;

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CHR_NINE) begin
      v = c - CHR_ZERO;
    end else begin
      v = (c & CASE_MASK) - CHR_A + HEX_TEN;
    end
    return v;
  endfunction

endpackage

### hdl/stx_etx_hex_checksum_deframer.sv
// ----------------------------------------------------------------------------
// stx_etx_hex_checksum_deframer
// Start/end framed byte deframer with a two-character ASCII hex sum check.
// ----------------------------------------------------------------------------
// The block accepts one received byte per clock cycle while the consumer
// does not stall, and shows its result, if any, on the master side: a byte
// goes into an input register, the frame logic decides on it in one pass,
// and the outcome lands in a result register that holds while the
// consumer stalls. Payload bytes leave before the checksum is known, so a
// consumer keeps them only if the closing result, marked by tlast, reports
// status ok.
module stx_etx_hex_checksum_deframer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sthc_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [7:0]                      cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] rx_byte
  input  logic [7:0]                      s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] out_byte, [9:8] frame_status, [17:10] received_sum,
  // [25:18] computed_sum, [31:26] zero
  output logic [sthc_pkg::TDATA_W-1:0]    m_axis_tdata,
  // frame_end
  output logic                            m_axis_tlast
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  sthc_pkg::result_t out_q;
  sthc_pkg::result_t res;
  logic [7:0]        start_code_q, end_code_q;
  logic              advance;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  sthc_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .rx_byte_i    (in_byte_q),
    .start_code_i (start_code_q),
    .end_code_i   (end_code_q),
    .res_o        (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      start_code_q <= sthc_pkg::START_RST;
      end_code_q   <= sthc_pkg::END_RST;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          sthc_pkg::CFG_START: start_code_q <= cfg_wdata_i;
          sthc_pkg::CFG_END:   end_code_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.frame_end;
  assign m_axis_tdata  = {6'b000000, out_q.computed_sum, out_q.received_sum,
                          out_q.frame_status, out_q.out_byte};

endmodule

### hdl/sthc_frame.sv
// ----------------------------------------------------------------------------
// sthc_frame
// Frame state, running sum, held checksum characters and closing decision.
// ----------------------------------------------------------------------------
module sthc_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [7:0]         start_code_i,
  input  logic [7:0]         end_code_i,
  output sthc_pkg::result_t  res_o
);

  logic                       in_frame_q, in_frame_d;
  logic [sthc_pkg::CNT_W-1:0] count_q, count_d;
  logic [7:0]                 sum_q, sum_d;
  logic [7:0]                 older_q, older_d;
  logic [7:0]                 newer_q, newer_d;
  logic [7:0]                 hv, lv, rs;

  assign hv = sthc_pkg::hex_val(older_q);
  assign lv = sthc_pkg::hex_val(newer_q);
  assign rs = (hv << 4) | lv;

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    sum_d      = sum_q;
    older_d    = older_q;
    newer_d    = newer_q;
    res_o      = '0;
    if (!in_frame_q) begin
      if (rx_byte_i == start_code_i) begin
        in_frame_d = 1'b1;
        count_d    = '0;
        sum_d      = rx_byte_i;
        older_d    = '0;
        newer_d    = '0;
      end
    end else if (rx_byte_i == end_code_i) begin
      res_o.valid        = 1'b1;
      res_o.frame_end    = 1'b1;
      res_o.computed_sum = sum_q;
      if (count_q == '0) begin
        res_o.frame_status = sthc_pkg::ST_EMPTY;
      end else if (count_q < sthc_pkg::CNT_W'(3)) begin
        res_o.frame_status = sthc_pkg::ST_CSUM;
      end else begin
        res_o.received_sum = rs;
        res_o.frame_status = (rs == sum_q) ? sthc_pkg::ST_OK : sthc_pkg::ST_CSUM;
      end
      in_frame_d = 1'b0;
      count_d    = '0;
      sum_d      = '0;
      older_d    = '0;
      newer_d    = '0;
    end else if (count_q >= sthc_pkg::CNT_W'(sthc_pkg::MAX_FRAME - 2)) begin
      res_o.valid        = 1'b1;
      res_o.frame_end    = 1'b1;
      res_o.frame_status = sthc_pkg::ST_OVER;
      res_o.computed_sum = sum_q;
      in_frame_d = 1'b0;
      count_d    = '0;
      sum_d      = '0;
      older_d    = '0;
      newer_d    = '0;
    end else begin
      count_d = count_q + sthc_pkg::CNT_W'(1);
      older_d = newer_q;
      newer_d = rx_byte_i;
      if (count_q >= sthc_pkg::CNT_W'(2)) begin
        sum_d          = sum_q + older_q;
        res_o.valid    = 1'b1;
        res_o.out_byte = older_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      sum_q      <= '0;
      older_q    <= '0;
      newer_q    <= '0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      older_q    <= older_d;
      newer_q    <= newer_d;
    end
  end

endmodule

### hdl/sthc_checker.sv
// ----------------------------------------------------------------------------
// sthc_checker
// Port-level checks on the result stream of the deframer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sthc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [sthc_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);

  logic stalled;
  logic payload;
  logic closing;

  assign stalled = m_axis_tvalid && !m_axis_tready;
  assign payload = m_axis_tvalid && !m_axis_tlast;
  assign closing = m_axis_tvalid && m_axis_tlast;

  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")
  `ASSERT_IMPL(a_payload_clean, clk_i, rst_ni, payload, m_axis_tdata[31:8] == 24'd0, "payload result carries status fields")
  `ASSERT_IMPL(a_close_clean, clk_i, rst_ni, closing, m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[31:26] == 6'd0, "closing result carries a payload byte")
  `ASSERT_IMPL(a_ok_match, clk_i, rst_ni, closing && m_axis_tdata[9:8] == sthc_pkg::ST_OK, m_axis_tdata[17:10] == m_axis_tdata[25:18], "ok status with differing sums")
  `ASSERT_IMPL(a_nodecode_zero, clk_i, rst_ni, closing && (m_axis_tdata[9:8] == sthc_pkg::ST_EMPTY || m_axis_tdata[9:8] == sthc_pkg::ST_OVER), m_axis_tdata[17:10] == 8'd0, "received sum set without decoding")

endmodule

bind stx_etx_hex_checksum_deframer sthc_checker u_sthc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
